// ===== hdl/pipc_pkg.sv =====
`timescale 1ns / 1ps

package pipc_pkg;

  // Q format of the controller output and its history
  localparam int FRACTION_BITS_DEF = 16;
  localparam int STEP_BITS = 24;
  localparam int GAIN_BITS = 16;
  localparam int COUNT_BITS = 8;
  localparam int DUTY_BITS = 8;
  localparam int ERR_BITS = 10;   // degree error, -360..360
  localparam int GAIN_ERR_BITS = 26;   // gained error, signed

  // Configuration port
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP = 1'd1;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd700;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 24'd16777;

  // count -> degree: floor(m * 360 / 255) = floor(m * 24 / 17)
  // = (m * 24 * 15421) >> 18, exact for m in 0..255
  localparam int ERR_SCALE_BITS = 27;
  localparam logic [ERR_SCALE_BITS-1:0] ERR_RECIP = 27'd370104;
  localparam int ERR_SHIFT = 18;

  localparam int OUT_HIGH = 126;
  localparam int OUT_LOW = -127;
  localparam int DUTY_OFFSET = 127;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GAIN,
    S_INTEG,
    S_SUM
  } pipc_state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;     // capture the degree error of a new sample
    logic gain;     // form the gained error
    logic integ;    // form the integral product and the error difference
    logic finish;   // sum, clamp, update history, load output register
  } pipc_cmd_t;

endpackage

// ===== hdl/pipc_ctrl.sv =====
`timescale 1ns / 1ps

module pipc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pipc_pkg::pipc_cmd_t cmd
);
  import pipc_pkg::*;

  pipc_state_t state;
  pipc_state_t state_next;
  logic        out_valid_next;
  logic        can_finish;

  // The output register is free when empty or being drained this cycle
  assign can_finish = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_GAIN;
      S_GAIN:  state_next = S_INTEG;
      S_INTEG: state_next = S_SUM;
      S_SUM:   if (can_finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_GAIN:  cmd.gain = 1'b1;
      S_INTEG: cmd.integ = 1'b1;
      S_SUM: begin
        cmd.finish = can_finish;
        if (can_finish) out_valid_next = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/pipc_datapath.sv =====
`timescale 1ns / 1ps

module pipc_datapath #(
  parameter int FRACTION_BITS = pipc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pipc_pkg::pipc_cmd_t                 cmd,
  input  logic                                cfg_write,
  input  logic [pipc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pipc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [pipc_pkg::COUNT_BITS-1:0]     command_count,
  input  logic [pipc_pkg::COUNT_BITS-1:0]     feedback_count,
  output logic [pipc_pkg::DUTY_BITS-1:0]      duty_value,
  output logic                                saturated
);
  import pipc_pkg::*;

  localparam int GSUM_BITS = GAIN_ERR_BITS + 1;
  localparam int PROD_BITS = GSUM_BITS + STEP_BITS + 1;
  localparam int SHIFT = STEP_BITS + 1 - FRACTION_BITS;
  localparam int OW = GSUM_BITS + FRACTION_BITS + 2;
  localparam int PVW = DUTY_BITS + FRACTION_BITS;
  localparam logic signed [PROD_BITS-1:0] RND =
    (PROD_BITS'(1) <<< SHIFT) - PROD_BITS'(1);
  localparam logic signed [OW-1:0] O_HI = OW'(OUT_HIGH) <<< FRACTION_BITS;
  localparam logic signed [OW-1:0] O_LO = OW'(OUT_LOW) <<< FRACTION_BITS;

  logic [GAIN_BITS-1:0]             gain;
  logic [STEP_BITS-1:0]             step;
  logic signed [GAIN_ERR_BITS-1:0]  g_prev;
  logic signed [PVW-1:0]            prev_o;
  logic signed [ERR_BITS-1:0]       err_reg;
  logic signed [GAIN_ERR_BITS-1:0]  g_reg;
  logic signed [PROD_BITS-1:0]      prod_reg;
  logic signed [GSUM_BITS-1:0]      gdiff_reg;

  logic signed [COUNT_BITS:0]       cdiff;
  logic [COUNT_BITS:0]              cdiff_neg;
  logic [COUNT_BITS-1:0]            cmag;
  logic [ERR_SCALE_BITS-1:0]        scaled;
  logic [ERR_BITS-2:0]              err_mag;
  logic signed [ERR_BITS-1:0]       err_next;
  logic signed [GSUM_BITS-1:0]      g_full;
  logic signed [GSUM_BITS-1:0]      gsum;
  logic signed [PROD_BITS-1:0]      prod_next;
  logic signed [PROD_BITS-1:0]      prod_adj;
  logic signed [PROD_BITS-1:0]      integ;
  logic signed [OW-1:0]             o_sum;
  logic signed [OW-1:0]             o_cl;
  logic                             sat_next;
  logic signed [PVW-1:0]            o_keep;
  logic [DUTY_BITS-1:0]             whole;
  logic                             round_up;
  logic [DUTY_BITS-1:0]             duty_next;

  // Degree error, truncated toward zero: scale the magnitude, restore sign
  assign cdiff     = $signed({1'b0, command_count}) - $signed({1'b0, feedback_count});
  assign cdiff_neg = -cdiff;
  assign cmag      = cdiff[COUNT_BITS] ? cdiff_neg[COUNT_BITS-1:0] : cdiff[COUNT_BITS-1:0];
  assign scaled    = ERR_SCALE_BITS'(cmag) * ERR_RECIP;
  assign err_mag   = scaled[ERR_SHIFT +: ERR_BITS-1];
  assign err_next  = cdiff[COUNT_BITS] ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});

  assign g_full    = err_reg * $signed({1'b0, gain});
  assign gsum      = g_reg + g_prev;
  assign prod_next = gsum * $signed({1'b0, step});

  // Halve and bring to the output Q format, toward zero
  assign prod_adj  = prod_reg + (prod_reg[PROD_BITS-1] ? RND : '0);
  assign integ     = prod_adj >>> SHIFT;
  assign o_sum     = (OW'(gdiff_reg) <<< FRACTION_BITS) + OW'(prev_o) + OW'(integ);

  always_comb begin
    o_cl     = o_sum;
    sat_next = 1'b0;
    if (o_sum > O_HI) begin
      o_cl     = O_HI;
      sat_next = 1'b1;
    end else if (o_sum < O_LO) begin
      o_cl     = O_LO;
      sat_next = 1'b1;
    end
  end

  assign o_keep    = o_cl[PVW-1:0];
  assign whole     = o_keep[PVW-1:FRACTION_BITS];
  assign round_up  = o_keep[PVW-1] && (|o_keep[FRACTION_BITS-1:0]);
  assign duty_next = whole + DUTY_BITS'(DUTY_OFFSET) + DUTY_BITS'(round_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      step   <= STEP_RESET;
      g_prev <= '0;
      prev_o <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GAIN: gain <= cfg_data[GAIN_BITS-1:0];
          REG_STEP: step <= cfg_data[STEP_BITS-1:0];
          default:  gain <= gain;
        endcase
      end
      if (cmd.finish) begin
        g_prev <= g_reg;
        prev_o <= o_keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) err_reg <= err_next;
    if (cmd.gain) g_reg <= g_full[GAIN_ERR_BITS-1:0];
    if (cmd.integ) begin
      prod_reg  <= prod_next;
      gdiff_reg <= g_reg - g_prev;
    end
    if (cmd.finish) begin
      duty_value <= duty_next;
      saturated  <= sat_next;
    end
  end

endmodule

// ===== hdl/pi_position_controller_tustin_core.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+--------------------------------------
// in       | in  | in_valid / in_stall  | command_count[7:0], feedback_count[7:0]
// out      | out | out_valid / out_stall| duty_value[7:0], saturated
// cfg      | in  | cfg_write            | cfg_index[0], cfg_data[23:0]
//
// Each transaction steps through error capture, gain multiply, integral
// multiply, then sum/clamp into the output register; the two multiplies
// share nothing but run in sequence.
// A new input is taken in the cycle after the previous result is loaded, even
// while that result still waits under out_stall; a full, stalled output
// register holds the sum step. Synchronous reset (rst) restores gain 700,
// step 16777 and clears the controller history.
module pi_position_controller_tustin_core #(
  parameter int FRACTION_BITS = pipc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pipc_pkg::COUNT_BITS-1:0]     command_count,
  input  logic [pipc_pkg::COUNT_BITS-1:0]     feedback_count,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pipc_pkg::DUTY_BITS-1:0]      duty_value,
  output logic                                saturated,
  input  logic                                cfg_write,
  input  logic [pipc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [pipc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import pipc_pkg::*;

  pipc_cmd_t cmd;

  // Sequencer: steps one sample through the datapath, owns the handshakes
  pipc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: gain registers, controller history, arithmetic, output payload
  pipc_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command_count  (command_count),
    .feedback_count (feedback_count),
    .duty_value     (duty_value),
    .saturated      (saturated)
  );

endmodule

// ===== tb/sv/tb_pi_position_controller_tustin_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Tustin PI position controller core.
// A directed table runs first. It starts right after reset and reprograms
// gain and step between groups of rows. Random phases follow, each under
// its own register setting. Every accepted sample goes through a local
// model of the controller, and each result that comes out is checked
// against the oldest prediction.
module tb_pi_position_controller_tustin_core;
  import pipc_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int RANDOM_PHASES = 6;
  localparam int HOLD_CYCLES = 60;      // long receiver hold-off
  localparam int RUSH_ITEMS = 30;       // back-to-back samples during a hold
  localparam int SETTLE_CYCLES = 8;     // block latency plus margin
  localparam int STALL_LIMIT = 2000;    // cycles without any transaction
  localparam int MAX_GAP = 12;
  localparam logic [CFG_DATA_BITS-1:0] CFG_ALL_ONES = '1;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic                 sat;
  } duty_result_t;

  typedef struct {
    logic                     reconfig;   // drain, then load gain and step
    logic [CFG_DATA_BITS-1:0] gain_data;
    logic [CFG_DATA_BITS-1:0] step_data;
    logic [COUNT_BITS-1:0]    cmd;
    logic [COUNT_BITS-1:0]    fb;
    logic                     pinned;     // expected result typed in below
    logic [DUTY_BITS-1:0]     duty;
    logic                     sat;
  } stim_row_t;

  // Rows with a typed-in result follow from the clamps or from a zero
  // error alone. Rows without one go to the model.
  stim_row_t directed_rows [22] = '{
    // reset gains: zero error, full-scale errors of either sign, then smaller errors
    '{1'b0, 24'd0, 24'd0, 8'd0,   8'd0,   1'b1, 8'd127, 1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd255, 8'd0,   1'b1, 8'd253, 1'b1},
    '{1'b0, 24'd0, 24'd0, 8'd0,   8'd255, 1'b1, 8'd0,   1'b1},
    '{1'b0, 24'd0, 24'd0, 8'd128, 8'd128, 1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd1,   8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd0,   8'd1,   1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd170, 8'd85,  1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd85,  8'd170, 1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd254, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd255, 8'd254, 1'b0, 8'd0,   1'b0},
    // all-ones data: the gain register keeps only its low 16 bits
    '{1'b1, CFG_ALL_ONES, CFG_ALL_ONES, 8'd255, 8'd0, 1'b1, 8'd253, 1'b1},
    '{1'b0, 24'd0, 24'd0, 8'd0,   8'd255, 1'b1, 8'd0,   1'b1},
    // unit gain, no integral: repeat an error to land exactly on a limit
    '{1'b1, 24'd1, 24'd0, 8'd200, 8'd100, 1'b1, 8'd253, 1'b1},
    '{1'b0, 24'd0, 24'd0, 8'd200, 8'd100, 1'b1, 8'd253, 1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd100, 8'd200, 1'b1, 8'd0,   1'b1},
    '{1'b0, 24'd0, 24'd0, 8'd100, 8'd200, 1'b1, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd101, 8'd100, 1'b0, 8'd0,   1'b0},
    // zero gain, full step
    '{1'b1, 24'd0, CFG_ALL_ONES, 8'd255, 8'd0, 1'b0, 8'd0, 1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd0,   8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd15,  8'd240, 1'b0, 8'd0,   1'b0},
    '{1'b0, 24'd0, 24'd0, 8'd240, 8'd15,  1'b0, 8'd0,   1'b0}
  };

  // Register settings of the random phases. The last two are drawn at run time.
  logic [CFG_DATA_BITS-1:0] phase_gain [4] = '{24'd2, 24'hAB0005, 24'd700, 24'd1};
  logic [CFG_DATA_BITS-1:0] phase_step [4] = '{24'd838850, 24'd0, 24'd16777, CFG_ALL_ONES};

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [COUNT_BITS-1:0]     command_count;
  logic [COUNT_BITS-1:0]     feedback_count;
  logic                      out_valid;
  logic                      out_stall;
  logic [DUTY_BITS-1:0]      duty_value;
  logic                      saturated;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Typed-in expectation that travels with the current sample
  logic                 pin_en;
  logic [DUTY_BITS-1:0] pin_duty;
  logic                 pin_sat;

  // Controller model: registers and history
  longint ctl_gain;
  longint ctl_step;
  longint hist_gained_err;
  longint hist_output;

  duty_result_t duty_expect_q [$];
  duty_result_t predicted;
  duty_result_t observed;

  int errors = 0;
  int idle_cycles = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int rush_left = 0;
  int sent_count = 0;
  int taken_count = 0;
  bit tx_busy = 1'b1;
  bit rx_busy = 1'b1;
  int rx_gap;
  int pick;
  int delta;
  int fb_int;
  logic [COUNT_BITS-1:0]    cmd_r;
  logic [COUNT_BITS-1:0]    fb_r;
  logic [CFG_DATA_BITS-1:0] gain_r;
  logic [CFG_DATA_BITS-1:0] step_r;

  pi_position_controller_tustin_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command_count  (command_count),
    .feedback_count (feedback_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .duty_value     (duty_value),
    .saturated      (saturated),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Arithmetic right shift that truncates toward zero instead of down
  function automatic longint shift_toward_zero(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v) >>> k);
  endfunction

  // One Tustin PI update. Advance the history and return duty and clamp flag.
  function automatic duty_result_t tustin_update(logic [COUNT_BITS-1:0] cmd,
                                                 logic [COUNT_BITS-1:0] fb);
    longint cmd_i, fb_i, err_deg, gained, integ, o_q, whole, one_q;
    duty_result_t r;
    cmd_i = cmd;
    fb_i = fb;
    one_q = longint'(1) <<< FRAC;
    // counts to degrees, truncated toward zero
    err_deg = ((cmd_i - fb_i) * 360) / 255;
    gained = err_deg * ctl_gain;
    // step is Q0.24: drop 24 bits, halve, and keep FRAC of them
    integ = shift_toward_zero((gained + hist_gained_err) * ctl_step, STEP_BITS + 1 - FRAC);
    o_q = (gained - hist_gained_err) * one_q + hist_output + integ;
    r.sat = 1'b0;
    if (o_q > OUT_HIGH * one_q) begin
      o_q = OUT_HIGH * one_q;
      r.sat = 1'b1;
    end else if (o_q < OUT_LOW * one_q) begin
      o_q = OUT_LOW * one_q;
      r.sat = 1'b1;
    end
    whole = shift_toward_zero(o_q, FRAC);
    r.duty = DUTY_BITS'(whole + DUTY_OFFSET);
    hist_gained_err = gained;
    hist_output = o_q;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  // Monitor: track register writes, predict each accepted sample and check
  // each accepted result. Everything is sampled at the rising edge, before
  // the block's own updates of that edge land.
  always @(posedge clk) begin
    if (rst) begin
      ctl_gain = GAIN_RESET;
      ctl_step = STEP_RESET;
      hist_gained_err = 0;
      hist_output = 0;
      duty_expect_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_GAIN) ctl_gain = cfg_data[GAIN_BITS-1:0];
        else if (cfg_index == REG_STEP) ctl_step = cfg_data[STEP_BITS-1:0];
      end
      if (in_valid && !in_stall) begin
        predicted = tustin_update(command_count, feedback_count);
        // a typed-in result replaces the model's for this transaction
        if (pin_en) begin
          predicted.duty = pin_duty;
          predicted.sat = pin_sat;
        end
        duty_expect_q.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        observed.duty = duty_value;
        observed.sat = saturated;
        if (duty_expect_q.size() == 0) begin
          report_mismatch("unexpected result duty_value", observed.duty, -1);
        end else begin
          predicted = duty_expect_q.pop_front();
          if (observed.duty !== predicted.duty)
            report_mismatch("duty_value", observed.duty, predicted.duty);
          if (observed.sat !== predicted.sat)
            report_mismatch("saturated", observed.sat, predicted.sat);
        end
      end
    end
  end

  // Watchdog: end the run once no transaction of any kind has moved for
  // too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall for a random number of cycles before each result,
  // with stretches of zero stall. Hold off for a long stretch whenever
  // the sender asks, so that the block backs up into its input.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_served < hold_requests) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rx_gap = rx_busy ? $urandom_range(0, MAX_GAP) : 0;
      if (rx_gap > 0) begin
        out_stall <= 1'b1;
        repeat (rx_gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken_count++;
      if (taken_count % 40 == 0) rx_busy = ($urandom_range(0, 2) != 0);
    end
  end

  // Offer one sample after a random gap. Hold valid and payload until
  // the block accepts them.
  task automatic send_sample(input logic [COUNT_BITS-1:0] cmd,
                             input logic [COUNT_BITS-1:0] fb,
                             input logic pin, input logic [DUTY_BITS-1:0] duty,
                             input logic sat);
    int gap;
    gap = (tx_busy && rush_left == 0) ? $urandom_range(0, MAX_GAP) : 0;
    if (rush_left > 0) rush_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command_count <= cmd;
    feedback_count <= fb;
    pin_en <= pin;
    pin_duty <= duty;
    pin_sat <= sat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    if (sent_count % 40 == 0) tx_busy = ($urandom_range(0, 2) != 0);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  // Then give the block time to settle back to idle.
  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load both registers on back-to-back cycles. Call only while idle.
  task automatic write_regs(input logic [CFG_DATA_BITS-1:0] gain_data,
                            input logic [CFG_DATA_BITS-1:0] step_data);
    cfg_write <= 1'b1;
    cfg_index <= REG_GAIN;
    cfg_data <= gain_data;
    @(posedge clk);
    cfg_index <= REG_STEP;
    cfg_data <= step_data;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command_count = '0;
    feedback_count = '0;
    cfg_write = 1'b0;
    cfg_index = REG_GAIN;
    cfg_data = '0;
    pin_en = 1'b0;
    pin_duty = '0;
    pin_sat = 1'b0;
    cmd_r = '0;
    fb_r = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table, starting from the reset gains
    foreach (directed_rows[i]) begin
      if (directed_rows[i].reconfig) begin
        drain_results();
        write_regs(directed_rows[i].gain_data, directed_rows[i].step_data);
      end
      send_sample(directed_rows[i].cmd, directed_rows[i].fb, directed_rows[i].pinned,
                  directed_rows[i].duty, directed_rows[i].sat);
    end

    // Random phases, one register setting each
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      if (ph < 4) begin
        gain_r = phase_gain[ph];
        step_r = phase_step[ph];
      end else if (ph == 4) begin
        gain_r = CFG_DATA_BITS'($urandom_range(0, 16));
        step_r = CFG_DATA_BITS'($urandom_range(0, 24'hFFFFFF));
      end else begin
        gain_r = CFG_DATA_BITS'($urandom);
        step_r = CFG_DATA_BITS'($urandom);
      end
      write_regs(gain_r, step_r);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // twice in the run: long receiver hold with samples back to back
        if ((ph == 1 || ph == 4) && n == 20) begin
          hold_requests++;
          rush_left = RUSH_ITEMS;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          // small errors keep the loop out of the clamps most of the time
          cmd_r = COUNT_BITS'($urandom_range(0, 255));
          delta = $urandom_range(0, 6) - 3;
          fb_int = int'(cmd_r) + delta;
          if (fb_int < 0) fb_int = 0;
          if (fb_int > 255) fb_int = 255;
          fb_r = fb_int[COUNT_BITS-1:0];
        end else if (pick < 8) begin
          cmd_r = COUNT_BITS'($urandom);
          fb_r = COUNT_BITS'($urandom);
        end
        // otherwise repeat the last sample so the output can settle on a limit
        send_sample(cmd_r, fb_r, 1'b0, '0, 1'b0);
      end
    end

    drain_results();
    if (errors == 0 && duty_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
